/* sv/rtud_pkg.sv */
`default_nettype none

package rtud_pkg;

	localparam int MAX_ADU_BYTES = 256;
	localparam int MIN_FRAME_BYTES = 4;
	localparam int COUNT_W = $clog2(MAX_ADU_BYTES + 3);
	localparam int LEN_W = 9;
	localparam int TICKS_W = 16;

	localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(MAX_ADU_BYTES + 2);
	localparam logic [TICKS_W-1:0] SILENCE_RESET = 16'd4100;
	localparam logic [LEN_W-1:0] MAX_ADU_RESET = 9'd256;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef enum logic [1:0] {
		REQ_BYTE  = 2'd0,
		REQ_TICK  = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_FRAME    = 2'd2,
		ST_CRC      = 2'd3
	} status_t;

	typedef enum logic {
		CFG_SILENCE = 1'b0,
		CFG_MAX_ADU = 1'b1
	} cfg_idx_t;

	// One byte of the reflected Modbus CRC-16, bit by bit.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
		input logic [7:0] data);
		logic [15:0] crc;
		crc = crc_in ^ {8'h00, data};
		for (int i = 0; i < 8; i++) begin
			if (crc[0]) begin
				crc = (crc >> 1) ^ CRC_POLY;
			end else begin
				crc = crc >> 1;
			end
		end
		return crc;
	endfunction

endpackage

`default_nettype wire

/* sv/rtu_receive_deframer_unit.sv */
// A result appears in the output register in the cycle after the transaction that causes it.
// Throughput: one input transaction per cycle; input ready stays high while the output
// register is empty or is being emptied in the same cycle.
// Reset (arst_n low, asynchronous): timer idle, frame cleared, CRC at 0xFFFF,
// silence_ticks 4100, largest ADU length 256, output register empty.
`default_nettype none

module rtu_receive_deframer_unit
	import rtud_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [15:0]       cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        req_type,
	input  wire logic [7:0]        rx_byte,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   frame_end,
	output logic [7:0]             data_byte,
	output logic [1:0]             frame_status,
	output logic [LEN_W-1:0]       payload_len
);

	logic [TICKS_W-1:0] silence_ticks_q;
	logic [LEN_W-1:0]   max_adu_q;

	logic [15:0]        crc_q;
	logic [COUNT_W-1:0] byte_count_q;
	logic               overflow_q;
	logic [7:0]         held0_q;
	logic [7:0]         held1_q;
	logic [TICKS_W-1:0] silence_count_q;
	logic               timer_active_q;

	logic               accept;
	logic               emit;
	logic               emit_end;
	logic [7:0]         emit_data;
	status_t            emit_status;
	logic [LEN_W-1:0]   emit_len;
	logic [TICKS_W-1:0] silence_next;
	logic               expired;
	logic               frame_bad;
	req_t               req;

	assign req      = req_t'(req_type);
	assign in_ready = !out_valid || out_ready;
	assign accept   = in_valid && in_ready;

	assign silence_next = (silence_count_q == {TICKS_W{1'b1}}) ? silence_count_q
		: silence_count_q + TICKS_W'(1);
	assign expired = timer_active_q && (silence_next >= silence_ticks_q);

	assign frame_bad = (max_adu_q == '0)
		|| (byte_count_q < COUNT_W'(MIN_FRAME_BYTES))
		|| ((LEN_W + 1)'(byte_count_q) > ({1'b0, max_adu_q} + (LEN_W + 1)'(2)));

	always_comb begin
		emit        = 1'b0;
		emit_end    = 1'b0;
		emit_data   = '0;
		emit_status = ST_OK;
		emit_len    = '0;
		unique case (req)
			REQ_BYTE: begin
				if (byte_count_q < COUNT_LIMIT && byte_count_q >= COUNT_W'(2)) begin
					emit      = 1'b1;
					emit_data = held0_q;
				end
			end
			REQ_TICK: begin
				if (expired && (byte_count_q != '0 || overflow_q)) begin
					emit     = 1'b1;
					emit_end = 1'b1;
					priority if (overflow_q) begin
						emit_status = ST_OVERFLOW;
					end else if (frame_bad) begin
						emit_status = ST_FRAME;
					end else if (crc_q != 16'h0000) begin
						emit_status = ST_CRC;
					end else begin
						emit_status = ST_OK;
						emit_len    = LEN_W'(byte_count_q) - LEN_W'(2);
					end
				end
			end
			REQ_CLEAR, REQ_NONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			silence_ticks_q <= SILENCE_RESET;
			max_adu_q       <= MAX_ADU_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SILENCE: silence_ticks_q <= cfg_data;
				CFG_MAX_ADU: max_adu_q <= cfg_data[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q           <= CRC_INIT;
			byte_count_q    <= '0;
			overflow_q      <= 1'b0;
			held0_q         <= '0;
			held1_q         <= '0;
			silence_count_q <= '0;
			timer_active_q  <= 1'b0;
		end else if (accept) begin
			unique case (req)
				REQ_BYTE: begin
					if (byte_count_q < COUNT_LIMIT) begin
						if (byte_count_q >= COUNT_W'(2)) begin
							held0_q <= held1_q;
							held1_q <= rx_byte;
						end else if (byte_count_q == '0) begin
							held0_q <= rx_byte;
						end else begin
							held1_q <= rx_byte;
						end
						byte_count_q <= byte_count_q + COUNT_W'(1);
						crc_q        <= crc16_byte(crc_q, rx_byte);
					end else begin
						overflow_q <= 1'b1;
					end
					silence_count_q <= '0;
					timer_active_q  <= 1'b1;
				end
				REQ_TICK: begin
					if (timer_active_q) begin
						if (expired) begin
							// Expiry always leaves a clean receiver, whether or not a status goes out.
							crc_q           <= CRC_INIT;
							byte_count_q    <= '0;
							overflow_q      <= 1'b0;
							held0_q         <= '0;
							held1_q         <= '0;
							silence_count_q <= '0;
							timer_active_q  <= 1'b0;
						end else begin
							silence_count_q <= silence_next;
						end
					end
				end
				REQ_CLEAR: begin
					crc_q           <= CRC_INIT;
					byte_count_q    <= '0;
					overflow_q      <= 1'b0;
					held0_q         <= '0;
					held1_q         <= '0;
					silence_count_q <= '0;
					timer_active_q  <= 1'b0;
				end
				REQ_NONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (accept) begin
			out_valid <= emit;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			frame_end    <= emit_end;
			data_byte    <= emit_data;
			frame_status <= emit_status;
			payload_len  <= emit_len;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= COUNT_LIMIT)
		else $error("byte count beyond the frame limit");

	a_idle_timer_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!timer_active_q |-> silence_count_q == '0)
		else $error("silence count running while the timer is idle");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req == REQ_CLEAR |=> byte_count_q == '0 && !overflow_q && !timer_active_q)
		else $error("clear transaction left frame state behind");

	a_ok_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end && frame_status == ST_OK |-> payload_len >= LEN_W'(2))
		else $error("ok status with a length below the minimum frame");

	a_err_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end && frame_status != ST_OK |-> payload_len == '0)
		else $error("error status with a nonzero length");
`endif

endmodule

`default_nettype wire
